// ===== sv/eoq_pkg.sv =====
`default_nettype none
package eoq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int FLOOR_COUNT   = 4;
  localparam int FLOOR_W       = 2;
  localparam int BUTTON_W      = 2;
  localparam int ENTRY_IDX_W   = 4;
  localparam int ORDER_COUNT_W = 5;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 16;

  typedef enum logic [1:0] {
    FUNC_PRESS   = 2'd0,
    FUNC_STEP    = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_PROMOTE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  localparam logic [BUTTON_W-1:0] BTN_UP   = 2'd0;
  localparam logic [BUTTON_W-1:0] BTN_DOWN = 2'd1;
  localparam logic [BUTTON_W-1:0] BTN_CAB  = 2'd2;

  typedef struct packed {
    logic [FLOOR_W-1:0]  floor;
    logic [BUTTON_W-1:0] button;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEW,
    CELL_PREV,
    CELL_NEXT
  } cell_op_e;

  // lookup key broadcast to all cells; button compared only when chk_button set
  typedef struct packed {
    logic [FLOOR_W-1:0]  floor;
    logic [BUTTON_W-1:0] button;
    logic                chk_button;
  } key_t;

endpackage
`default_nettype wire

// ===== sv/eoq_cell.sv =====
`default_nettype none
module eoq_cell
  import eoq_pkg::*;
(
  input  wire  logic     clk_i,
  input  wire  cell_op_e op_i,
  input  wire  logic     valid_i,
  input  wire  key_t     key_i,
  input  wire  entry_t   new_i,
  input  wire  entry_t   prev_i,
  input  wire  entry_t   next_i,
  input  wire  logic     hit_chain_i,
  output logic           hit_chain_o,
  output entry_t         entry_o
);

  entry_t entry_q;
  logic   hit;

  always_comb begin
    hit = valid_i && (entry_q.floor == key_i.floor) &&
          (!key_i.chk_button || (entry_q.button == key_i.button));
    hit_chain_o = hit_chain_i | hit;
    entry_o     = entry_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      CELL_HOLD: entry_q <= entry_q;
      CELL_NEW:  entry_q <= new_i;
      CELL_PREV: entry_q <= prev_i;
      CELL_NEXT: entry_q <= next_i;
      default:   entry_q <= entry_q;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/elevator_order_queue.sv =====
// Elevator call order queue.
// Input beats on s_axis carry one event each: tuser selects press, step, clear
// or promote, tdata carries the call floor and button, the last passed floor,
// the floor sensor and the promotion slot. Every input beat yields exactly one
// output beat on m_axis with the head order, motor command, door pulse, order
// count and accepted flag.
// Orders sit in a row of cells, slot 0 being the head; each cell can load a
// new order or take its neighbour's order, so appends, promotions and
// compaction are shifts along the row.
// Press, clear, promote and steps that do not serve a floor go through the
// execute and finish states; a new beat is taken only back in idle.
// A step that serves a floor adds a compact state that removes one order per
// cycle, every order at the passed floor, before the finish state.
// One event is in flight at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so the next beat is taken while it
// waits; the block stalls only when a second result would need that register.
// Reset empties the queue and sets the stored direction to stop; queue
// contents need no reset.
`default_nettype none
module elevator_order_queue
  import eoq_pkg::*;
(
  input  wire  logic                  clk_i,
  input  wire  logic                  rst_ni,
  input  wire  logic                  s_axis_tvalid,
  output logic                        s_axis_tready,
  // call_floor, call_button, passed_floor, at_floor, entry_index
  input  wire  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  wire  logic [1:0]            s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire  logic                  m_axis_tready,
  // head_valid, head_floor, head_button, motor_command, door_open, order_count, accepted
  output logic [OUT_DATA_W-1:0]       m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COMPACT,
    ST_FINISH
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        count_q;
  dir_e                    dir_q;
  func_e                   func_q;
  logic [FLOOR_W-1:0]      cf_q;
  logic [BUTTON_W-1:0]     cb_q;
  logic [FLOOR_W-1:0]      lf_q;
  logic                    sens_q;
  logic [ENTRY_IDX_W-1:0]  idx_q;
  dir_e                    motor_q;
  logic                    door_q;
  logic                    acc_q;
  logic                    m_valid_q;
  logic [OUT_DATA_W-1:0]   m_data_q;

  cell_op_e                cell_op   [QUEUE_DEPTH];
  entry_t                  cell_ent  [QUEUE_DEPTH];
  entry_t                  cell_prev [QUEUE_DEPTH];
  entry_t                  cell_next [QUEUE_DEPTH];
  logic                    cell_vld  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]    chain;
  key_t                    key;
  entry_t                  new_ent;
  entry_t                  sel_ent;
  entry_t                  head;
  logic                    head_vld;
  logic                    press_ok;
  logic                    promote_ok;
  logic                    dir_ok;
  logic signed [FLOOR_W:0] dl;
  logic signed [FLOOR_W:0] df;

  assign chain[0] = 1'b0;
  assign new_ent  = '{floor: cf_q, button: cb_q};

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign cell_vld[g]  = count_q > CNT_W'(g);
    assign cell_prev[g] = (g == 0) ? sel_ent : cell_ent[(g == 0) ? 0 : g - 1];
    assign cell_next[g] = (g == QUEUE_DEPTH - 1) ? '0 :
                          cell_ent[(g == QUEUE_DEPTH - 1) ? g : g + 1];
    eoq_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op[g]),
      .valid_i     (cell_vld[g]),
      .key_i       (key),
      .new_i       (new_ent),
      .prev_i      (cell_prev[g]),
      .next_i      (cell_next[g]),
      .hit_chain_i (chain[g]),
      .hit_chain_o (chain[g+1]),
      .entry_o     (cell_ent[g])
    );
  end

  always_comb begin
    head     = cell_ent[0];
    head_vld = count_q != '0;
    sel_ent  = cell_ent[0];
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (int'(idx_q) == i) begin
        sel_ent = cell_ent[i];
      end
    end

    if (state_q == ST_COMPACT) begin
      key = '{floor: lf_q, button: '0, chk_button: 1'b0};
    end else begin
      key = '{floor: cf_q, button: cb_q, chk_button: 1'b1};
    end

    press_ok = (cb_q <= BTN_CAB) && (int'(cf_q) < FLOOR_COUNT) &&
               !chain[QUEUE_DEPTH] && (int'(count_q) < QUEUE_DEPTH);

    dl = $signed({1'b0, sel_ent.floor}) - $signed({1'b0, lf_q});
    df = $signed({1'b0, head.floor}) - $signed({1'b0, lf_q});
    if (sel_ent.button == BTN_UP) begin
      dir_ok = df > 0;
    end else if (sel_ent.button == BTN_DOWN) begin
      dir_ok = df < 0;
    end else begin
      dir_ok = 1'b1;
    end
    promote_ok = (idx_q != '0) && (int'(idx_q) < int'(count_q)) &&
                 (int'(idx_q) < QUEUE_DEPTH) && dir_ok &&
                 ((df > 0 && dl > 0 && dl < df) || (df < 0 && dl < 0 && dl > df));

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (state_q == ST_EXEC && func_q == FUNC_PRESS && press_ok &&
          count_q == CNT_W'(i)) begin
        cell_op[i] = CELL_NEW;
      end else if (state_q == ST_EXEC && func_q == FUNC_PROMOTE && promote_ok &&
                   int'(idx_q) >= i) begin
        cell_op[i] = CELL_PREV;
      end else if (state_q == ST_COMPACT && chain[QUEUE_DEPTH] && chain[i+1]) begin
        cell_op[i] = CELL_NEXT;
      end
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      dir_q     <= DIR_STOP;
      m_valid_q <= 1'b0;
      func_q    <= FUNC_PRESS;
      motor_q   <= DIR_STOP;
      door_q    <= 1'b0;
      acc_q     <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != ST_FINISH) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            func_q  <= func_e'(s_axis_tuser);
            cf_q    <= s_axis_tdata[1:0];
            cb_q    <= s_axis_tdata[3:2];
            lf_q    <= s_axis_tdata[5:4];
            sens_q  <= s_axis_tdata[6];
            idx_q   <= s_axis_tdata[10:7];
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (func_q)
            FUNC_PRESS: begin
              motor_q <= DIR_STOP;
              door_q  <= 1'b0;
              acc_q   <= press_ok;
              state_q <= ST_FINISH;
              if (press_ok) begin
                count_q <= count_q + 1'b1;
              end
            end
            FUNC_STEP: begin
              acc_q <= 1'b0;
              if (head_vld && head.floor == lf_q && sens_q) begin
                motor_q <= DIR_STOP;
                dir_q   <= DIR_STOP;
                door_q  <= 1'b1;
                state_q <= ST_COMPACT;
              end else begin
                door_q  <= 1'b0;
                state_q <= ST_FINISH;
                if (!head_vld) begin
                  motor_q <= DIR_STOP;
                end else if (head.floor > lf_q) begin
                  motor_q <= DIR_UP;
                  dir_q   <= DIR_UP;
                end else if (head.floor < lf_q) begin
                  motor_q <= DIR_DOWN;
                  dir_q   <= DIR_DOWN;
                end else if (dir_q == DIR_UP) begin
                  motor_q <= DIR_DOWN;
                end else if (dir_q == DIR_DOWN) begin
                  motor_q <= DIR_UP;
                end else begin
                  motor_q <= DIR_STOP;
                end
              end
            end
            FUNC_CLEAR: begin
              motor_q <= DIR_STOP;
              door_q  <= 1'b0;
              acc_q   <= 1'b0;
              state_q <= ST_FINISH;
              count_q <= '0;
            end
            FUNC_PROMOTE: begin
              motor_q <= DIR_STOP;
              door_q  <= 1'b0;
              acc_q   <= promote_ok;
              state_q <= ST_FINISH;
            end
            default: state_q <= ST_FINISH;
          endcase
        end
        ST_COMPACT: begin
          if (chain[QUEUE_DEPTH]) begin
            count_q <= count_q - 1'b1;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {2'b00, acc_q, ORDER_COUNT_W'(count_q), door_q, motor_q,
                          head_vld ? head.button : BTN_UP,
                          head_vld ? head.floor : FLOOR_W'(0), head_vld};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
